### src/tawf_pkg.sv
// Shared types and constants for the Thumb ALU with kept NZCV flags.
`default_nettype none

package tawf_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned AMOUNT_W = 8;
    localparam int unsigned IMM_AMOUNT_W = 5;
    localparam int unsigned FUNC_W = 5;

    // Shift amount that stands for a full-word shift.
    localparam logic [AMOUNT_W-1:0] AMOUNT_WORD = AMOUNT_W'(WORD_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_AND     = 5'd0,
        FN_EOR     = 5'd1,
        FN_LSL_REG = 5'd2,
        FN_LSR_REG = 5'd3,
        FN_ASR_REG = 5'd4,
        FN_ADC     = 5'd5,
        FN_SBC     = 5'd6,
        FN_ROR     = 5'd7,
        FN_TST     = 5'd8,
        FN_NEG     = 5'd9,
        FN_CMP     = 5'd10,
        FN_CMN     = 5'd11,
        FN_ORR     = 5'd12,
        FN_MUL     = 5'd13,
        FN_BIC     = 5'd14,
        FN_ADD     = 5'd15,
        FN_SUB     = 5'd16,
        FN_MOV     = 5'd17,
        FN_ADD_NF  = 5'd18,
        FN_MOV_NF  = 5'd19,
        FN_LSL_IMM = 5'd20,
        FN_LSR_IMM = 5'd21,
        FN_ASR_IMM = 5'd22
    } t_func;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_kind;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              write_result;
        logic              flag_n;
        logic              flag_z;
        logic              flag_c;
        logic              flag_v;
    } t_out_word;

endpackage

`default_nettype wire

### src/thumb_alu_with_flags.sv
// Top level of the Thumb ALU: input register, ALU, result register and NZCV flags.
// A taken word passes from the input register through the combinational ALU into the
// result register, which drives the output word.
// Throughput: one word per cycle unless the output stalls; the combinational ALU and
// the flag register set it, since each word sees the flags left by the word just before it.
// Reset (synchronous, active low) empties both stages and clears N, Z, C and V.
// Payload registers are not reset; only their valid bits are.
`default_nettype none

module thumb_alu_with_flags (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 i_in_valid,
    output logic                     o_in_stall,
    input  var tawf_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  var logic                 i_out_stall,
    output tawf_pkg::t_out_word      o_out_word
);
    import tawf_pkg::*;

    // Stage one holds the accepted word; stage two holds the finished result.
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_flags    r_flags;

    logic      n_in_valid;
    logic      n_out_valid;
    t_flags    n_flags;

    t_out_word alu_word;
    logic      in_accept;
    logic      out_accept;
    logic      advance;

    // The word in stage one moves on when the result register is empty or is
    // being emptied in this same cycle. The flags are committed only then, so
    // the next word always computes against the flags of its predecessor.
    assign out_accept = r_out_valid && !i_out_stall;
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);

    // Stage one takes a new word whenever it is empty or its word moves on.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    tawf_alu u_alu (
        .i_word  (r_in_word),
        .i_flags (r_flags),
        .o_word  (alu_word)
    );

    always_comb begin
        n_flags.n = alu_word.flag_n;
        n_flags.z = alu_word.flag_z;
        n_flags.c = alu_word.flag_c;
        n_flags.v = alu_word.flag_v;
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (out_accept) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_flags <= n_flags;
            end
        end
    end

    // Payload registers load only on a transfer, so a stalled word holds.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= alu_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### src/tawf_shifter.sv
// Barrel shifter and rotator with the architectural carry-out rules.
`default_nettype none

module tawf_shifter (
    input  var tawf_pkg::t_shift_kind             i_kind,
    input  var logic [tawf_pkg::AMOUNT_W-1:0]     i_amount,
    input  var logic [tawf_pkg::WORD_W-1:0]       i_value,
    input  var logic                              i_carry,
    output logic [tawf_pkg::WORD_W-1:0]           o_value,
    output logic                                  o_carry
);
    import tawf_pkg::*;

    logic [IMM_AMOUNT_W-1:0] sh;
    logic                    amt_zero;
    logic                    amt_big;
    logic                    amt_exact;
    logic [WORD_W:0]         lsl_w;
    logic [WORD_W:0]         lsr_w;
    logic signed [WORD_W:0]  asr_w;
    logic [WORD_W-1:0]       ror_w;

    assign sh        = i_amount[IMM_AMOUNT_W-1:0];
    assign amt_zero  = (i_amount == '0);
    assign amt_big   = |i_amount[AMOUNT_W-1:IMM_AMOUNT_W];
    assign amt_exact = (i_amount == AMOUNT_WORD);

    // The extra bit on each side catches the last bit shifted out.
    assign lsl_w = {1'b0, i_value} << sh;
    assign lsr_w = {i_value, 1'b0} >> sh;
    assign asr_w = $signed({i_value, 1'b0}) >>> sh;
    assign ror_w = WORD_W'({i_value, i_value} >> sh);

    always_comb begin
        o_value = i_value;
        o_carry = i_carry;
        if (!amt_zero) begin
            case (i_kind)
                SH_LSL: begin
                    if (amt_big) begin
                        o_value = '0;
                        o_carry = amt_exact ? i_value[0] : 1'b0;
                    end else begin
                        o_value = lsl_w[WORD_W-1:0];
                        o_carry = lsl_w[WORD_W];
                    end
                end
                SH_LSR: begin
                    if (amt_big) begin
                        o_value = '0;
                        o_carry = amt_exact ? i_value[WORD_W-1] : 1'b0;
                    end else begin
                        o_value = lsr_w[WORD_W:1];
                        o_carry = lsr_w[0];
                    end
                end
                SH_ASR: begin
                    if (amt_big) begin
                        o_value = {WORD_W{i_value[WORD_W-1]}};
                        o_carry = i_value[WORD_W-1];
                    end else begin
                        o_value = asr_w[WORD_W:1];
                        o_carry = asr_w[0];
                    end
                end
                default: begin
                    // A rotate leaves the last bit moved round in bit 31.
                    o_value = ror_w;
                    o_carry = ror_w[WORD_W-1];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/tawf_alu.sv
// Combinational ALU: operation decode, adder, multiplier, shifter and flag update.
`default_nettype none

module tawf_alu (
    input  var tawf_pkg::t_in_word  i_word,
    input  var tawf_pkg::t_flags    i_flags,
    output tawf_pkg::t_out_word     o_word
);
    import tawf_pkg::*;

    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [WORD_W-1:0]   add_x;
    logic [WORD_W-1:0]   add_y;
    logic                add_cin;
    logic [WORD_W:0]     add_sum;
    logic                add_v;
    logic [WORD_W-1:0]   mul_lo;
    t_shift_kind         sh_kind;
    logic [AMOUNT_W-1:0] sh_amount;
    logic [WORD_W-1:0]   sh_value;
    logic                sh_carry;
    logic [AMOUNT_W-1:0] imm_amount;
    logic [AMOUNT_W-1:0] imm_amount_wide;
    logic [WORD_W-1:0]   res;
    logic                wr;
    logic                set_nz;
    t_flags              flags;

    assign a = i_word.operand_a;
    assign b = i_word.operand_b;

    assign mul_lo = a * b;

    // Immediate LSR and ASR read an amount of zero as a full-word shift.
    assign imm_amount      = AMOUNT_W'(b[IMM_AMOUNT_W-1:0]);
    assign imm_amount_wide = (imm_amount == '0) ? AMOUNT_WORD : imm_amount;

    always_comb begin
        sh_kind   = SH_LSL;
        sh_amount = imm_amount;
        case (i_word.func) inside
            FN_LSL_REG: begin
                sh_kind   = SH_LSL;
                sh_amount = b[AMOUNT_W-1:0];
            end
            FN_LSR_REG: begin
                sh_kind   = SH_LSR;
                sh_amount = b[AMOUNT_W-1:0];
            end
            FN_ASR_REG: begin
                sh_kind   = SH_ASR;
                sh_amount = b[AMOUNT_W-1:0];
            end
            FN_ROR: begin
                sh_kind   = SH_ROR;
                sh_amount = b[AMOUNT_W-1:0];
            end
            FN_LSR_IMM: begin
                sh_kind   = SH_LSR;
                sh_amount = imm_amount_wide;
            end
            FN_ASR_IMM: begin
                sh_kind   = SH_ASR;
                sh_amount = imm_amount_wide;
            end
            default: begin
                sh_kind   = SH_LSL;
                sh_amount = imm_amount;
            end
        endcase
    end

    tawf_shifter u_shifter (
        .i_kind   (sh_kind),
        .i_amount (sh_amount),
        .i_value  (a),
        .i_carry  (i_flags.c),
        .o_value  (sh_value),
        .o_carry  (sh_carry)
    );

    // Subtraction is addition of the inverted operand with carry in set, or with the carry flag for SBC.
    always_comb begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        case (i_word.func) inside
            FN_ADC: begin
                add_cin = i_flags.c;
            end
            FN_SBC: begin
                add_y   = ~b;
                add_cin = i_flags.c;
            end
            FN_NEG: begin
                add_x   = '0;
                add_y   = ~b;
                add_cin = 1'b1;
            end
            FN_CMP, FN_SUB: begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{WORD_W{1'b0}}, add_cin};
    assign add_v   = ~(add_x[WORD_W-1] ^ add_y[WORD_W-1])
                   & (add_x[WORD_W-1] ^ add_sum[WORD_W-1]);

    always_comb begin
        res    = '0;
        wr     = 1'b1;
        set_nz = 1'b1;
        flags  = i_flags;
        unique case (i_word.func) inside
            FN_AND, FN_TST: res = a & b;
            FN_EOR:         res = a ^ b;
            FN_ORR:         res = a | b;
            FN_BIC:         res = a & ~b;
            FN_MUL:         res = mul_lo;
            FN_MOV:         res = b;
            FN_LSL_REG, FN_LSR_REG, FN_ASR_REG, FN_ROR,
            FN_LSL_IMM, FN_LSR_IMM, FN_ASR_IMM: begin
                res     = sh_value;
                flags.c = sh_carry;
            end
            FN_ADC, FN_SBC, FN_NEG, FN_CMP, FN_CMN, FN_ADD, FN_SUB: begin
                res     = add_sum[WORD_W-1:0];
                flags.c = add_sum[WORD_W];
                flags.v = add_v;
            end
            FN_ADD_NF: begin
                res    = add_sum[WORD_W-1:0];
                set_nz = 1'b0;
            end
            FN_MOV_NF: begin
                res    = b;
                set_nz = 1'b0;
            end
            default: begin
                res    = '0;
                wr     = 1'b0;
                set_nz = 1'b0;
            end
        endcase
        // Compare and test report their value but do not write it back.
        if (i_word.func == FN_TST || i_word.func == FN_CMP || i_word.func == FN_CMN) begin
            wr = 1'b0;
        end
        if (set_nz) begin
            flags.n = res[WORD_W-1];
            flags.z = (res == '0);
        end
    end

    assign o_word.result       = res;
    assign o_word.write_result = wr;
    assign o_word.flag_n       = flags.n;
    assign o_word.flag_z       = flags.z;
    assign o_word.flag_c       = flags.c;
    assign o_word.flag_v       = flags.v;

endmodule

`default_nettype wire

### tb/thumb_alu_with_flags_test.sv
// Self-checking testbench for the Thumb ALU with kept NZCV flags.
`timescale 1ns / 100ps

module thumb_alu_with_flags_test;

    import tawf_pkg::*;

    // Operation codes past the last defined one do nothing at all.
    localparam logic [FUNC_W-1:0] FN_SPARE_MIN = 5'd23;
    localparam logic [FUNC_W-1:0] FN_SPARE_MAX = 5'd31;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_WORDS   = 950;
    localparam int MAX_WAIT       = 6;
    // Sender gap and receiver stall are each bounded by MAX_WAIT, so a long quiet
    // stretch can only mean a hang.
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 8;

    // One row of the directed table. When typed is set, want holds the result
    // word as written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word want;
    } t_stim_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Flags as the predictor sees them after the last accepted word.
    t_flags      kept_flags = '0;
    t_out_word   expected_alu_results[$];
    t_stim_row   stim_table[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned stall_left     = 0;
    int unsigned idle_cycles    = 0;
    logic        sender_quiet   = 1'b0;

    thumb_alu_with_flags dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Full-width add with carry in; returns the sum and gives the carry out
    // and the signed overflow. Subtraction goes through here as a + ~b + 1, or a + ~b + C for SBC.
    function automatic logic [WORD_W-1:0] add_with_carry(
        input  logic [WORD_W-1:0] x,
        input  logic [WORD_W-1:0] y,
        input  logic              cin,
        output logic              cout,
        output logic              ovf
    );
        logic [WORD_W:0] sum;
        sum  = {1'b0, x} + {1'b0, y} + {{WORD_W{1'b0}}, cin};
        cout = sum[WORD_W];
        ovf  = ~(x[WORD_W-1] ^ y[WORD_W-1]) & (x[WORD_W-1] ^ sum[WORD_W-1]);
        return sum[WORD_W-1:0];
    endfunction

    // Works out the result word of one ALU operation and advances the kept
    // flags the way the architecture does for the matching Thumb instruction.
    task automatic predict_alu(input t_in_word w, output t_out_word e);
        logic [WORD_W-1:0]       a;
        logic [WORD_W-1:0]       b;
        logic [WORD_W-1:0]       r;
        logic [AMOUNT_W-1:0]     s8;
        logic [IMM_AMOUNT_W-1:0] s5;
        logic                    n;
        logic                    z;
        logic                    c;
        logic                    v;
        logic                    wr;
        logic                    set_nz;
        a      = w.operand_a;
        b      = w.operand_b;
        s8     = b[AMOUNT_W-1:0];
        s5     = b[IMM_AMOUNT_W-1:0];
        {n, z, c, v} = kept_flags;
        r      = '0;
        wr     = 1'b1;
        set_nz = 1'b1;
        case (w.func)
            FN_AND: r = a & b;
            FN_EOR: r = a ^ b;
            FN_LSL_REG: begin
                if (s8 == 0) begin
                    r = a;
                end else if (s8 < WORD_W) begin
                    c = a[WORD_W - s8];
                    r = a << s8;
                end else begin
                    c = (s8 == AMOUNT_WORD) ? a[0] : 1'b0;
                    r = '0;
                end
            end
            FN_LSR_REG: begin
                if (s8 == 0) begin
                    r = a;
                end else if (s8 < WORD_W) begin
                    c = a[s8 - 1];
                    r = a >> s8;
                end else begin
                    c = (s8 == AMOUNT_WORD) ? a[WORD_W-1] : 1'b0;
                    r = '0;
                end
            end
            FN_ASR_REG: begin
                if (s8 == 0) begin
                    r = a;
                end else if (s8 < WORD_W) begin
                    c = a[s8 - 1];
                    r = $signed(a) >>> s8;
                end else begin
                    c = a[WORD_W-1];
                    r = {WORD_W{a[WORD_W-1]}};
                end
            end
            FN_ADC: r = add_with_carry(a, b, c, c, v);
            FN_SBC: r = add_with_carry(a, ~b, c, c, v);
            FN_ROR: begin
                if (s8 == 0) begin
                    r = a;
                end else if (s5 == 0) begin
                    c = a[WORD_W-1];
                    r = a;
                end else begin
                    c = a[s5 - 1];
                    r = (a >> s5) | (a << (WORD_W - s5));
                end
            end
            FN_TST: begin
                r  = a & b;
                wr = 1'b0;
            end
            FN_NEG: r = add_with_carry('0, ~b, 1'b1, c, v);
            FN_CMP: begin
                r  = add_with_carry(a, ~b, 1'b1, c, v);
                wr = 1'b0;
            end
            FN_CMN: begin
                r  = add_with_carry(a, b, 1'b0, c, v);
                wr = 1'b0;
            end
            FN_ORR: r = a | b;
            FN_MUL: r = a * b;
            FN_BIC: r = a & ~b;
            FN_ADD: r = add_with_carry(a, b, 1'b0, c, v);
            FN_SUB: r = add_with_carry(a, ~b, 1'b1, c, v);
            FN_MOV: r = b;
            FN_ADD_NF: begin
                r      = a + b;
                set_nz = 1'b0;
            end
            FN_MOV_NF: begin
                r      = b;
                set_nz = 1'b0;
            end
            FN_LSL_IMM: begin
                if (s5 == 0) begin
                    r = a;
                end else begin
                    c = a[WORD_W - s5];
                    r = a << s5;
                end
            end
            FN_LSR_IMM: begin
                // An amount of zero encodes a shift by a full word.
                if (s5 == 0) begin
                    c = a[WORD_W-1];
                    r = '0;
                end else begin
                    c = a[s5 - 1];
                    r = a >> s5;
                end
            end
            FN_ASR_IMM: begin
                if (s5 == 0) begin
                    c = a[WORD_W-1];
                    r = {WORD_W{a[WORD_W-1]}};
                end else begin
                    c = a[s5 - 1];
                    r = $signed(a) >>> s5;
                end
            end
            default: begin
                r      = '0;
                wr     = 1'b0;
                set_nz = 1'b0;
            end
        endcase
        if (set_nz) begin
            n = r[WORD_W-1];
            z = (r == '0);
        end
        kept_flags     = {n, z, c, v};
        e.result       = r;
        e.write_result = wr;
        e.flag_n       = n;
        e.flag_z       = z;
        e.flag_c       = c;
        e.flag_v       = v;
    endtask

    task automatic table_row(
        input logic [FUNC_W-1:0] f,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic              typed,
        input logic [WORD_W-1:0] r,
        input logic              wr,
        input logic [3:0]        nzcv
    );
        t_stim_row row;
        row.word.func      = f;
        row.word.operand_a = a;
        row.word.operand_b = b;
        row.typed          = typed;
        row.want           = {r, wr, nzcv};
        stim_table.push_back(row);
    endtask

    // Offers one word after a random gap and holds it until it is taken. The
    // valid line is only dropped when a gap follows, so back-to-back words
    // never see valid lowered and raised within the same time step.
    task automatic send_alu_word(input t_in_word w, input logic typed,
                                 input t_out_word want);
        int unsigned gap;
        t_out_word   predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        // The word was taken at this edge, so the flags move on now.
        predict_alu(w, predicted);
        expected_alu_results.push_back(typed ? want : predicted);
    endtask

    // Operands lean toward the corners where carry and overflow change.
    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 64);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_word random_alu_word();
        t_in_word w;
        if ($urandom_range(0, 9) == 0) begin
            w.func = FUNC_W'($urandom_range(FN_SPARE_MIN, FN_SPARE_MAX));
        end else begin
            w.func = FUNC_W'($urandom_range(FN_AND, FN_ASR_IMM));
        end
        w.operand_a = pick_operand();
        w.operand_b = pick_operand();
        // Shifts mostly get amounts around the word boundary, with random
        // upper bits that the block must ignore.
        case (w.func) inside
            FN_LSL_REG, FN_LSR_REG, FN_ASR_REG, FN_ROR,
            FN_LSL_IMM, FN_LSR_IMM, FN_ASR_IMM: begin
                case ($urandom_range(0, 3))
                    0: w.operand_b = {(WORD_W - AMOUNT_W)'($urandom()),
                                      AMOUNT_W'($urandom_range(0, 40))};
                    1: w.operand_b[AMOUNT_W-1:0] = AMOUNT_W'($urandom_range(0, 7) * WORD_W);
                    2: w.operand_b[AMOUNT_W-1:0] = AMOUNT_W'($urandom_range(0, 40));
                    default: w.operand_b = $urandom();
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (expected_alu_results.size() == 0) begin
            $display("%0t ns: result word with nothing expected, expected none, got %h",
                     $time, got);
            mismatch_count++;
        end else begin
            want = expected_alu_results.pop_front();
            compare_field("result", want.result, got.result);
            compare_field("write_result", WORD_W'(want.write_result),
                          WORD_W'(got.write_result));
            compare_field("flag_n", WORD_W'(want.flag_n), WORD_W'(got.flag_n));
            compare_field("flag_z", WORD_W'(want.flag_z), WORD_W'(got.flag_z));
            compare_field("flag_c", WORD_W'(want.flag_c), WORD_W'(got.flag_c));
            compare_field("flag_v", WORD_W'(want.flag_v), WORD_W'(got.flag_v));
        end
    endtask

    // Receiving side: takes result words and draws a fresh stall after each
    // one. Every fourth block of fifty results goes through with no stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                check_result(o_out_word);
                results_seen++;
                stall_left = (((results_seen / 50) % 4) == 3) ? 0
                                                              : $urandom_range(0, MAX_WAIT);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_in_word  w;
        t_out_word no_want;
        no_want = '0;

        // Rows with typed results start right after reset, where the flags
        // are known to be clear. Flags are written as {N, Z, C, V}.
        table_row(FN_AND, '1, '0, 1'b1, '0, 1'b1, 4'b0100);
        table_row(FN_SPARE_MAX, '1, '1, 1'b1, '0, 1'b0, 4'b0100);
        table_row(FN_ADD, 32'h7FFF_FFFF, 32'h1, 1'b1, 32'h8000_0000, 1'b1, 4'b1001);
        table_row(FN_ADD, '1, 32'h1, 1'b1, '0, 1'b1, 4'b0110);
        table_row(FN_CMP, '0, 32'h1, 1'b1, '1, 1'b0, 4'b1000);
        table_row(FN_MOV_NF, 32'h1234_5678, '0, 1'b1, '0, 1'b1, 4'b1000);
        table_row(FN_ADC, '1, '0, 1'b1, '1, 1'b1, 4'b1000);
        // From here on the predictor supplies the expected words.
        table_row(FN_EOR, 32'hA5A5_A5A5, '1, 1'b0, '0, 1'b0, 4'b0);
        // Register shift whose low byte is zero: value and carry pass through.
        table_row(FN_LSL_REG, 32'h8000_0001, 32'hFFFF_FF00, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_LSL_REG, 32'h0000_0003, 32'd32, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_LSL_REG, '1, 32'd33, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_LSR_REG, 32'h8000_0000, 32'd32, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_ASR_REG, 32'h8000_0000, 32'h0000_00FF, 1'b0, '0, 1'b0, 4'b0);
        // Rotate by a nonzero multiple of the word width, then by 36.
        table_row(FN_ROR, 32'h8000_0001, 32'd64, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_ROR, 32'h1234_5678, 32'h24, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_SBC, '0, '1, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_TST, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_NEG, '1, 32'h8000_0000, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_CMN, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_ORR, '0, '0, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_MUL, '1, '1, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_BIC, '1, 32'h0000_FFFF, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_SUB, 32'h8000_0000, 32'h1, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_MOV, '0, 32'h8000_0000, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_ADD_NF, '1, 32'h2, 1'b0, '0, 1'b0, 4'b0);
        // Immediate shifts with a zero amount field, then an ASR by 31.
        table_row(FN_LSL_IMM, 32'hC000_0000, 32'hFFFF_FFE0, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_LSR_IMM, 32'h8000_0000, '0, 1'b0, '0, 1'b0, 4'b0);
        table_row(FN_ASR_IMM, 32'h8000_0000, 32'h0000_001F, 1'b0, '0, 1'b0, 4'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            send_alu_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
        end

        // Random words; every fourth block of fifty goes out with no gaps.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sender_quiet = (((i / 50) % 4) == 1);
            w = random_alu_word();
            send_alu_word(w, 1'b0, no_want);
        end
        in_valid <= 1'b0;

        while (expected_alu_results.size() != 0) @(posedge clk);
        // A few more cycles so that any stray extra word is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### thumb_alu_with_flags.f
src/tawf_pkg.sv
src/tawf_shifter.sv
src/tawf_alu.sv
src/thumb_alu_with_flags.sv
tb/thumb_alu_with_flags_test.sv
